// ----- hw/rtl/sliding_window_maximum_unit_macros.svh -----
// assertion macros for the sliding window maximum checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_MACROS_SVH

// same-cycle implication, masked while reset is asserted
`define SWM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sliding window maximum check failed");

// next-cycle implication, masked while reset is asserted
`define SWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sliding window maximum check failed");

// condition that must hold in the cycle after reset is sampled
`define SWM_ASSERT_RST(label, cons) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
        else $error("sliding window maximum reset check failed");

`endif

// ----- hw/rtl/swm_pkg.sv -----
// shared types and constants for the sliding window maximum unit
// no dependencies
`default_nettype none

package swm_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRONT,
        ST_BACK,
        ST_OUT
    } t_swm_state;

    typedef struct packed {
        logic accept;
        logic drop_head;
        logic drop_tail;
        logic push;
        logic out_load;
    } t_swm_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic front_old;
        logic back_le;
        logic filled;
        logic out_free;
    } t_swm_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/swm_smp_if.sv -----
// sample input channel: valid/ready with sample and start_req
// no dependencies
`default_nettype none

interface swm_smp_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swm_res_if.sv -----
// result output channel: valid/ready with window_max
// no dependencies
`default_nettype none

interface swm_res_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swm_cfg_if.sv -----
// configuration write channel carrying the window_size register
// depends on swm_pkg
`default_nettype none

interface swm_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [swm_pkg::CFG_W-1:0]   window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swm_ctrl.sv -----
// sequencer for the sliding window maximum unit
// depends on swm_pkg; drives commands into swm_dp and reads its status
`default_nettype none

module swm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire swm_pkg::t_swm_sts i_sts,
    output logic                   o_in_ready,
    output swm_pkg::t_swm_cmd      o_cmd
);

    swm_pkg::t_swm_state r_state;
    swm_pkg::t_swm_state n_state;

    logic out_go;
    logic front_pop;
    logic back_pop;

    // result slot free, or nothing to deliver for this sample
    assign out_go    = !i_sts.filled || i_sts.out_free;
    assign front_pop = !i_sts.cnt_zero && i_sts.front_old;
    assign back_pop  = !i_sts.cnt_zero && i_sts.back_le;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = swm_pkg::ST_FRONT;
                end
            end
            swm_pkg::ST_FRONT: begin
                if (!front_pop) begin
                    n_state = swm_pkg::ST_BACK;
                end
            end
            swm_pkg::ST_BACK: begin
                if (!back_pop) begin
                    n_state = swm_pkg::ST_OUT;
                end
            end
            swm_pkg::ST_OUT: begin
                if (out_go) begin
                    n_state = i_in_valid ? swm_pkg::ST_FRONT : swm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = swm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            swm_pkg::ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
            end
            swm_pkg::ST_FRONT: begin
                o_cmd.drop_head = front_pop;
            end
            swm_pkg::ST_BACK: begin
                o_cmd.drop_tail = back_pop;
                o_cmd.push      = !back_pop;
            end
            swm_pkg::ST_OUT: begin
                // next sample overlaps with handing off this result
                o_in_ready     = out_go;
                o_cmd.accept   = out_go && i_in_valid;
                o_cmd.out_load = i_sts.filled && i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/swm_dp.sv -----
// datapath: candidate deque memory, pointers, position counter, result register
// depends on swm_pkg, swm_res_if, swm_cfg_if; commanded by swm_ctrl
`default_nettype none

module swm_dp #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                          i_start_req,
    input  wire swm_pkg::t_swm_cmd             i_cmd,
    output swm_pkg::t_swm_sts                  o_sts,
    swm_res_if.source                          o_res,
    swm_cfg_if.sink                            i_cfg
);

    localparam int IDX_W   = $clog2(WINDOW_MAX);
    localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
    localparam int POS_MOD = 2 * WINDOW_MAX;
    localparam int POS_W   = $clog2(POS_MOD);
    localparam int AGE_W   = POS_W + 1;
    localparam int SUM_W   = CNT_W + 1;
    localparam int CMP_W   = (CNT_W > swm_pkg::CFG_W) ? CNT_W : swm_pkg::CFG_W;
    localparam int ENT_W   = POS_W + SAMPLE_BITS;

    // wrap a pointer sum below 2*WINDOW_MAX back into the deque range
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
        if (s >= SUM_W'(WINDOW_MAX)) begin
            return IDX_W'(s - SUM_W'(WINDOW_MAX));
        end
        return IDX_W'(s);
    endfunction

    logic [ENT_W-1:0] mem [WINDOW_MAX];

    logic [swm_pkg::CFG_W-1:0]   r_window_size;
    logic [IDX_W-1:0]            r_head;
    logic [IDX_W-1:0]            n_head;
    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;
    logic [POS_W-1:0]            r_pos;
    logic [POS_W-1:0]            n_pos;
    logic                        r_filled;
    logic                        n_filled;
    logic                        r_fwd;
    logic                        n_fwd;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [ENT_W-1:0]            r_rd_a;
    logic [ENT_W-1:0]            r_rd_b;
    logic                        r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_data;

    logic [CMP_W-1:0]            cfg_ext;
    logic [CNT_W-1:0]            w_eff;
    logic [POS_W-1:0]            front_pos;
    logic [AGE_W-1:0]            age;
    logic [IDX_W-1:0]            head_inc;
    logic [IDX_W-1:0]            addr_a;
    logic [IDX_W-1:0]            addr_b;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_idx;

    // zero acts as one, oversize saturates
    assign cfg_ext = CMP_W'(r_window_size);
    assign w_eff   = (cfg_ext == '0) ? CNT_W'(1) :
                     (cfg_ext > CMP_W'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) : CNT_W'(cfg_ext);

    // distance from the front entry to the current position, modulo POS_MOD
    assign front_pos = r_rd_a[ENT_W-1:SAMPLE_BITS];
    assign age = (r_pos >= front_pos) ?
                 ({1'b0, r_pos} - {1'b0, front_pos}) :
                 ({1'b0, r_pos} + AGE_W'(POS_MOD) - {1'b0, front_pos});

    assign head_inc = wrap_idx(SUM_W'(r_head) + SUM_W'(1));

    assign o_sts.cnt_zero  = (r_count == '0);
    assign o_sts.front_old = (age >= AGE_W'(w_eff));
    assign o_sts.back_le   = (r_sample >= $signed(r_rd_b[SAMPLE_BITS-1:0]));
    assign o_sts.filled    = r_filled;
    assign o_sts.out_free  = !r_out_valid || o_res.ready;

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_pos    = r_pos;
        n_filled = r_filled;
        n_fwd    = r_fwd;
        wr_en    = 1'b0;
        wr_idx   = r_head;
        if (i_cmd.accept && i_start_req) begin
            n_head   = '0;
            n_count  = '0;
            n_pos    = '0;
            n_filled = 1'b0;
        end
        if (i_cmd.drop_head) begin
            n_head  = head_inc;
            n_count = r_count - CNT_W'(1);
        end
        if (i_cmd.drop_tail) begin
            n_count = r_count - CNT_W'(1);
        end
        if (i_cmd.push) begin
            wr_en = 1'b1;
            n_fwd = (r_count == '0);
            if (r_count == CNT_W'(WINDOW_MAX)) begin
                // full deque: the oldest slot is reused for the new entry
                n_head = head_inc;
                wr_idx = r_head;
            end else begin
                wr_idx  = wrap_idx(SUM_W'(r_head) + SUM_W'(r_count));
                n_count = r_count + CNT_W'(1);
            end
            if ({1'b0, r_pos} + AGE_W'(1) >= AGE_W'(w_eff)) begin
                n_filled = 1'b1;
            end
            n_pos = (r_pos == POS_W'(POS_MOD - 1)) ? '0 : r_pos + POS_W'(1);
        end
    end

    // read ports follow the next pointers so data is ready in the following cycle
    assign addr_a = n_head;
    assign addr_b = (n_count == '0) ? n_head :
                    wrap_idx(SUM_W'(n_head) + SUM_W'(n_count) - SUM_W'(1));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= {r_pos, r_sample};
        end
        r_rd_a <= mem[addr_a];
        r_rd_b <= mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= swm_pkg::CFG_RESET;
            r_head        <= '0;
            r_count       <= '0;
            r_pos         <= '0;
            r_filled      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_window_size <= i_cfg.window_size;
            end
            r_head   <= n_head;
            r_count  <= n_count;
            r_pos    <= n_pos;
            r_filled <= n_filled;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd <= n_fwd;
        if (i_cmd.accept) begin
            r_sample <= i_sample;
        end
        if (i_cmd.out_load) begin
            // a lone entry was written this sample, take it from the sample register
            r_out_data <= r_fwd ? r_sample : $signed(r_rd_a[SAMPLE_BITS-1:0]);
        end
    end

    assign i_cfg.ready      = 1'b1;
    assign o_res.valid      = r_out_valid;
    assign o_res.window_max = r_out_data;

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_maximum_unit.sv -----
// sliding window maximum unit, top level
// depends on swm_pkg, swm_smp_if, swm_res_if, swm_cfg_if, swm_ctrl, swm_dp
//
// i_smp carries one sample per beat with start_req; start_req high clears the
// window and makes that sample the first of a new sequence. o_res carries one
// window_max beat per sample once window_size samples of the sequence are in;
// earlier samples give no result. i_cfg writes window_size (zero acts as one,
// values above WINDOW_MAX saturate) and is always ready; write it only while
// the unit is idle, and a change applies from the next sample on.
// A sample passes through the front, back and out states; it stays in the front
// or back state while it drops a candidate from that end of the deque, and each
// candidate is dropped at most once. The deque walk drops one candidate a cycle
// through the registered read ports of the candidate memory. The result is
// registered and is loaded in the out state once the result slot is free. A
// waiting result does not block the next sample, but that sample's own result
// holds the unit until the receiver takes the last.
// Synchronous active-low reset empties the deque, sets window_size to 3 and
// drops any pending result; the candidate memory needs no clearing.
`default_nettype none

module sliding_window_maximum_unit #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    swm_smp_if.sink    i_smp,
    swm_res_if.source  o_res,
    swm_cfg_if.sink    i_cfg
);

    swm_pkg::t_swm_cmd cmd;
    swm_pkg::t_swm_sts sts;
    logic              in_ready;

    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_smp.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    swm_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (i_smp.sample),
        .i_start_req (i_smp.start_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_res       (o_res),
        .i_cfg       (i_cfg)
    );

    assign i_smp.ready = in_ready;

endmodule

`default_nettype wire

// ----- hw/rtl/swm_checker.sv -----
// port-level checks for the sliding window maximum unit, bound to the top level
// depends on sliding_window_maximum_unit_macros.svh and sliding_window_maximum_unit
`default_nettype none

`include "sliding_window_maximum_unit_macros.svh"

module swm_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [SAMPLE_BITS-1:0] i_window_max
);

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // a stalled result beat holds
    `SWM_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_window_max))
    // each sample passes through its front and back states before another is accepted
    `SWM_ASSERT_NEXT(a_no_accept_next, in_acc, !in_acc)
    `SWM_ASSERT_SAME(a_no_accept_two, in_acc, ##2 !in_acc)
    // reset drops any pending result
    `SWM_ASSERT_RST(a_rst_out_idle, !i_out_valid)

endmodule

bind sliding_window_maximum_unit swm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_out_valid  (o_res.valid),
    .i_out_ready  (o_res.ready),
    .i_window_max (o_res.window_max)
);

`default_nettype wire
